### rtl/core/sfd_pkg.sv
// Shared types and constants for the stuffed frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESC_FLAG    = 8'h5E;
    localparam logic [7:0] ESC_ESC     = 8'h5D;
    localparam logic [7:0] ESC_XOR     = 8'h20;
    localparam logic [7:0] SYNC_FIRST_RST  = 8'h7E;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h33;

    localparam int         STAGE_DEPTH = 14;
    localparam logic [4:0] FRAME_LEN   = 5'd17;
    localparam logic [4:0] COUNT_MAX   = 5'd18;
    localparam logic [4:0] STAGE_FIRST = 5'd2;
    localparam logic [4:0] STAGE_LAST  = 5'd15;

    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST  = 8'd0,
        REG_SYNC_SECOND = 8'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SYNC   = 2'd1,
        ST_LENGTH = 2'd2
    } status_t;

    // per-frame parse state
    typedef struct packed {
        logic       escape_pending;
        logic [1:0] raw_position;
        logic       sync_good;
        logic [4:0] unstuffed_count;
    } frame_t;

    localparam frame_t FRAME_RST = '{
        escape_pending:  1'b0,
        raw_position:    2'd0,
        sync_good:       1'b1,
        unstuffed_count: 5'd0
    };

    typedef logic [STAGE_DEPTH-1:0][7:0] stage_t;

    typedef struct packed {
        logic    done;
        logic    hold;
        status_t status;
    } verdict_t;

endpackage

### rtl/core/sfd_intf.sv
// Handshake channel interfaces for the deframer: raw bytes, results, configuration.
`timescale 1ns / 1ps

interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       last_byte;

    modport source (output valid, output raw_byte, output last_byte, input ready);
    modport sink   (input valid, input raw_byte, input last_byte, output ready);
endinterface

interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  message_type;
    logic [7:0]  message_subtype;
    logic [31:0] value_one;
    logic [31:0] value_two;
    logic [31:0] value_three;

    modport source (output valid, output status, output message_type,
                    output message_subtype, output value_one, output value_two,
                    output value_three, input ready);
    modport sink   (input valid, input status, input message_type,
                    input message_subtype, input value_one, input value_two,
                    input value_three, output ready);
endinterface

interface sfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/sfd_unstuff.sv
// Next-state logic for one raw byte: sync check, unstuffing, staging writes, verdict.
`timescale 1ns / 1ps

module sfd_unstuff (
    input  sfd_pkg::frame_t   cur,
    input  sfd_pkg::stage_t   stage_cur,
    input  logic [7:0]        raw_byte,
    input  logic              last_byte,
    input  logic [7:0]        sync_first,
    input  logic [7:0]        sync_second,
    output sfd_pkg::frame_t   nxt,
    output sfd_pkg::stage_t   stage_nxt,
    output sfd_pkg::verdict_t verdict
);
    import sfd_pkg::*;

    logic       esc;
    logic       sync;
    logic [1:0] pos;
    logic [4:0] cnt;
    logic       consumed;
    logic       emit_a;
    logic       emit_b;
    logic       emit_c;
    logic [7:0] byte_a;
    stage_t     stg;

    always_comb
    begin
        esc      = cur.escape_pending;
        sync     = cur.sync_good;
        pos      = cur.raw_position;
        cnt      = cur.unstuffed_count;
        stg      = stage_cur;
        consumed = 1'b0;
        emit_a   = 1'b0;
        emit_b   = 1'b0;
        emit_c   = 1'b0;
        byte_a   = ESCAPE_BYTE;

        if (pos == 2'd0 && raw_byte != sync_first)
            sync = 1'b0;
        if (pos == 2'd1 && raw_byte != sync_second)
            sync = 1'b0;
        if (pos != 2'd2)
            pos = pos + 2'd1;

        // pending escape resolves first
        if (esc)
        begin
            esc    = 1'b0;
            emit_a = 1'b1;
            if (raw_byte == ESC_FLAG || raw_byte == ESC_ESC)
            begin
                byte_a   = raw_byte ^ ESC_XOR;
                consumed = 1'b1;
            end
        end
        if (!consumed)
        begin
            if (raw_byte == ESCAPE_BYTE)
                esc = 1'b1;
            else
                emit_b = 1'b1;
        end
        // trailing escape is literal
        if (last_byte && esc)
        begin
            esc    = 1'b0;
            emit_c = 1'b1;
        end
        if (last_byte && pos != 2'd2)
            sync = 1'b0;

        // at most two of the three slots fire in one word
        if (emit_a)
        begin
            if (cnt >= STAGE_FIRST && cnt <= STAGE_LAST)
                stg[4'(cnt - STAGE_FIRST)] = byte_a;
            if (cnt < COUNT_MAX)
                cnt = cnt + 5'd1;
        end
        if (emit_b)
        begin
            if (cnt >= STAGE_FIRST && cnt <= STAGE_LAST)
                stg[4'(cnt - STAGE_FIRST)] = raw_byte;
            if (cnt < COUNT_MAX)
                cnt = cnt + 5'd1;
        end
        if (emit_c)
        begin
            if (cnt >= STAGE_FIRST && cnt <= STAGE_LAST)
                stg[4'(cnt - STAGE_FIRST)] = ESCAPE_BYTE;
            if (cnt < COUNT_MAX)
                cnt = cnt + 5'd1;
        end

        stage_nxt    = stg;
        verdict.done = last_byte;
        verdict.hold = 1'b0;
        if (!sync)
            verdict.status = ST_SYNC;
        else if (cnt != FRAME_LEN)
            verdict.status = ST_LENGTH;
        else
        begin
            verdict.status = ST_OK;
            verdict.hold   = last_byte;
        end

        if (last_byte)
            nxt = FRAME_RST;
        else
        begin
            nxt.escape_pending  = esc;
            nxt.raw_position    = pos;
            nxt.sync_good       = sync;
            nxt.unstuffed_count = cnt;
        end
    end

endmodule

### rtl/core/stuffed_frame_deframer.sv
// Byte-unstuffing frame deframer: input register, one-pass parse, result register.
// A last word is held in the input register, parsed, and its status then lands in the result register.
// Throughput: one word per cycle unless a last word stalls; the parse of a word is one combinational pass.
// A pending result stalls only the next last word; ordinary words keep flowing.
// Reset: frame state clears, held fields zero, sync registers 0x7E and 0x33.
`timescale 1ns / 1ps

module stuffed_frame_deframer (
    input  logic      clk,
    input  logic      rst_n,
    sfd_in_if.sink    din,
    sfd_out_if.source dout,
    sfd_cfg_if.sink   cfg
);
    import sfd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    frame_t      frame_reg;
    frame_t      frame_next;
    stage_t      stage_reg;
    stage_t      stage_next;
    verdict_t    verdict;
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic        out_valid_reg;
    status_t     status_reg;
    logic [7:0]  type_reg;
    logic [7:0]  subtype_reg;
    logic [31:0] value_one_reg;
    logic [31:0] value_two_reg;
    logic [31:0] value_three_reg;
    logic        out_free;
    logic        advance;
    logic        fire;

    assign out_free = !out_valid_reg || dout.ready;
    assign advance  = !in_valid_reg || !last_reg || out_free;
    assign fire     = in_valid_reg && advance;
    assign din.ready = advance;
    assign cfg.ready = 1'b1;

    sfd_unstuff u_unstuff (
        .cur         (frame_reg),
        .stage_cur   (stage_reg),
        .raw_byte    (byte_reg),
        .last_byte   (last_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .nxt         (frame_next),
        .stage_nxt   (stage_next),
        .verdict     (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            frame_reg       <= FRAME_RST;
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            type_reg        <= '0;
            subtype_reg     <= '0;
            value_one_reg   <= '0;
            value_two_reg   <= '0;
            value_three_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_SYNC_FIRST:  sync_first_reg  <= cfg.data;
                    REG_SYNC_SECOND: sync_second_reg <= cfg.data;
                    default: ;
                endcase
            end

            if (advance)
                in_valid_reg <= din.valid;

            if (fire && verdict.done)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;

            if (fire)
            begin
                frame_reg <= frame_next;
                if (verdict.done)
                    status_reg <= verdict.status;
                if (verdict.hold)
                begin
                    type_reg        <= stage_next[0];
                    subtype_reg     <= stage_next[1];
                    value_one_reg   <= {stage_next[5], stage_next[4],
                                        stage_next[3], stage_next[2]};
                    value_two_reg   <= {stage_next[9], stage_next[8],
                                        stage_next[7], stage_next[6]};
                    value_three_reg <= {stage_next[13], stage_next[12],
                                        stage_next[11], stage_next[10]};
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (advance && din.valid)
        begin
            byte_reg <= din.raw_byte;
            last_reg <= din.last_byte;
        end
        if (fire)
            stage_reg <= stage_next;
    end

    assign dout.valid           = out_valid_reg;
    assign dout.status          = status_reg;
    assign dout.message_type    = type_reg;
    assign dout.message_subtype = subtype_reg;
    assign dout.value_one       = value_one_reg;
    assign dout.value_two       = value_two_reg;
    assign dout.value_three     = value_three_reg;

endmodule

### verif/stuffed_frame_deframer_test.sv
// Self-checking bench for the stuffed frame deframer: directed frames, then random frames.
`timescale 1ns / 1ps

module stuffed_frame_deframer_test;
    import sfd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 6;
    localparam int PHASE_WORDS     = 80;
    localparam int PHASE_RESULTS   = 4;
    localparam int N_DIRECTED      = 25;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        status_t     status;
        logic [7:0]  frame_type;
        logic [7:0]  frame_subtype;
        logic [31:0] value_one;
        logic [31:0] value_two;
        logic [31:0] value_three;
    } frame_result_t;

    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        logic       pinned;
        status_t    pin_status;
    } directed_row_t;

    logic clk;
    logic rst_n;

    sfd_in_if  raw_ch ();
    sfd_out_if res_ch ();
    sfd_cfg_if cfg_ch ();

    stuffed_frame_deframer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (raw_ch),
        .dout  (res_ch),
        .cfg   (cfg_ch)
    );

    // short buffer, a good frame full of escapes, bad second sync byte, short good sync
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{SYNC_FIRST_RST,  1'b1, 1'b1, ST_SYNC},
        '{SYNC_FIRST_RST,  1'b0, 1'b0, ST_OK},
        '{SYNC_SECOND_RST, 1'b0, 1'b0, ST_OK},
        '{8'h01,           1'b0, 1'b0, ST_OK},
        '{ESCAPE_BYTE,     1'b0, 1'b0, ST_OK},
        '{ESC_FLAG,        1'b0, 1'b0, ST_OK},
        '{ESCAPE_BYTE,     1'b0, 1'b0, ST_OK},
        '{ESC_ESC,         1'b0, 1'b0, ST_OK},
        '{8'hFF,           1'b0, 1'b0, ST_OK},
        '{8'h00,           1'b0, 1'b0, ST_OK},
        '{8'h80,           1'b0, 1'b0, ST_OK},
        '{ESCAPE_BYTE,     1'b0, 1'b0, ST_OK},
        '{8'h41,           1'b0, 1'b0, ST_OK},
        '{8'h7F,           1'b0, 1'b0, ST_OK},
        '{8'h01,           1'b0, 1'b0, ST_OK},
        '{ESCAPE_BYTE,     1'b0, 1'b0, ST_OK},
        '{ESCAPE_BYTE,     1'b0, 1'b0, ST_OK},
        '{ESC_FLAG,        1'b0, 1'b0, ST_OK},
        '{8'h55,           1'b0, 1'b0, ST_OK},
        '{8'hAA,           1'b0, 1'b0, ST_OK},
        '{ESCAPE_BYTE,     1'b1, 1'b0, ST_OK},
        '{SYNC_FIRST_RST,  1'b0, 1'b0, ST_OK},
        '{8'hFF,           1'b1, 1'b1, ST_SYNC},
        '{SYNC_FIRST_RST,  1'b0, 1'b0, ST_OK},
        '{SYNC_SECOND_RST, 1'b1, 1'b1, ST_LENGTH}
    };

    // deframer shadow state
    logic [7:0]  cur_sync_first;
    logic [7:0]  cur_sync_second;
    frame_t      frame_st;
    logic [7:0]  staged [STAGE_DEPTH];
    logic [7:0]  held_type;
    logic [7:0]  held_subtype;
    logic [31:0] held_values [3];

    frame_result_t expected_frames [$];
    logic [7:0]    frame_raw [$];

    int mismatches        = 0;
    int predicted_results = 0;
    int words_sent        = 0;
    int hold_requests     = 0;
    int hold_served       = 0;
    int hold_left         = 0;
    int quiet_cycles      = 0;
    bit calm              = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void store_unstuffed(input logic [7:0] b);
        if (frame_st.unstuffed_count >= STAGE_FIRST && frame_st.unstuffed_count <= STAGE_LAST)
            staged[4'(frame_st.unstuffed_count - STAGE_FIRST)] = b;
        if (frame_st.unstuffed_count < COUNT_MAX)
            frame_st.unstuffed_count = frame_st.unstuffed_count + 5'd1;
    endfunction

    function automatic logic [31:0] staged_word(input logic [3:0] base);
        return {staged[base + 4'd3], staged[base + 4'd2], staged[base + 4'd1], staged[base]};
    endfunction

    // advance the shadow state by one raw word; returns 1 when a status word is due
    function automatic bit deframe_word(input logic [7:0] b, input logic last,
                                        output frame_result_t res);
        logic consumed;
        consumed = 1'b0;
        res = '0;
        if (frame_st.raw_position == 2'd0 && b != cur_sync_first)
            frame_st.sync_good = 1'b0;
        if (frame_st.raw_position == 2'd1 && b != cur_sync_second)
            frame_st.sync_good = 1'b0;
        if (frame_st.raw_position < 2'd2)
            frame_st.raw_position = frame_st.raw_position + 2'd1;

        if (frame_st.escape_pending)
        begin
            frame_st.escape_pending = 1'b0;
            if (b == ESC_FLAG || b == ESC_ESC)
            begin
                store_unstuffed(b ^ ESC_XOR);
                consumed = 1'b1;
            end
            else
                store_unstuffed(ESCAPE_BYTE);
        end
        if (!consumed)
        begin
            if (b == ESCAPE_BYTE)
                frame_st.escape_pending = 1'b1;
            else
                store_unstuffed(b);
        end

        if (!last)
            return 1'b0;

        // dangling escape at buffer end counts as a literal
        if (frame_st.escape_pending)
            store_unstuffed(ESCAPE_BYTE);
        if (frame_st.raw_position < 2'd2)
            frame_st.sync_good = 1'b0;

        if (!frame_st.sync_good)
            res.status = ST_SYNC;
        else if (frame_st.unstuffed_count != FRAME_LEN)
            res.status = ST_LENGTH;
        else
        begin
            res.status     = ST_OK;
            held_type      = staged[0];
            held_subtype   = staged[1];
            held_values[0] = staged_word(4'd2);
            held_values[1] = staged_word(4'd6);
            held_values[2] = staged_word(4'd10);
        end
        frame_st = FRAME_RST;

        res.frame_type    = held_type;
        res.frame_subtype = held_subtype;
        res.value_one     = held_values[0];
        res.value_two     = held_values[1];
        res.value_three   = held_values[2];
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return ESCAPE_BYTE;
            1:       return ESC_FLAG ^ ESC_XOR;
            2:       return ESC_FLAG;
            3:       return ESC_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // append n payload bytes, stuffed: escape bytes always, flag bytes only at random
    function automatic void push_payload(input int n);
        logic [7:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = pick_byte();
            if (v == ESCAPE_BYTE || (v == (ESC_FLAG ^ ESC_XOR) && $urandom_range(0, 1) == 1))
            begin
                frame_raw.push_back(ESCAPE_BYTE);
                frame_raw.push_back(v ^ ESC_XOR);
            end
            else
                frame_raw.push_back(v);
        end
    endfunction

    function automatic void build_frame();
        int         kind;
        int         pos;
        logic [7:0] x;
        frame_raw.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 90)
        begin
            // line noise of random length, down to a single byte
            repeat ($urandom_range(1, 24))
                frame_raw.push_back(pick_byte());
            return;
        end
        frame_raw.push_back(cur_sync_first);
        frame_raw.push_back(cur_sync_second);
        if (kind < 60)
            push_payload(15);
        else if (kind < 70)
            push_payload($urandom_range(0, 1) ? $urandom_range(12, 14) : $urandom_range(16, 23));
        else if (kind < 80)
        begin
            push_payload(15);
            pos = $urandom_range(0, 1);
            frame_raw[pos] = frame_raw[pos] ^ 8'($urandom_range(1, 255));
        end
        else if (kind < 85)
        begin
            push_payload(14);
            frame_raw.push_back(ESCAPE_BYTE);
        end
        else
        begin
            // escape followed by an ordinary byte: both count
            push_payload(13);
            frame_raw.push_back(ESCAPE_BYTE);
            do
                x = 8'($urandom_range(0, 255));
            while (x == ESC_FLAG || x == ESC_ESC || x == ESCAPE_BYTE);
            frame_raw.push_back(x);
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [7:0] b, input logic last,
                             input logic pinned, input status_t pin_status);
        frame_result_t res;
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            raw_ch.valid = 1'b0;
            @(negedge clk);
        end
        raw_ch.valid     = 1'b1;
        raw_ch.raw_byte  = b;
        raw_ch.last_byte = last;
        do
            @(posedge clk);
        while (!raw_ch.ready);
        if (deframe_word(b, last, res))
        begin
            if (pinned)
                res.status = pin_status;
            expected_frames.push_back(res);
            predicted_results++;
        end
        words_sent++;
        @(negedge clk);
        raw_ch.valid = 1'b0;
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [7:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_SYNC_FIRST)
            cur_sync_first = value;
        else
            cur_sync_second = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_frames.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // pace changes land on a rising edge so the receiver sees them at a fixed point
    task automatic set_pace(input bit no_idle, input bit hold);
        @(posedge clk);
        calm = no_idle;
        if (hold)
            hold_requests++;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [7:0] first, input logic [7:0] second);
        int words_goal;
        int results_goal;
        write_register(REG_SYNC_FIRST, first);
        write_register(REG_SYNC_SECOND, second);
        words_goal   = words_sent + PHASE_WORDS;
        results_goal = predicted_results + PHASE_RESULTS;
        while (words_sent < words_goal || predicted_results < results_goal)
        begin
            build_frame();
            for (int i = 0; i < frame_raw.size(); i++)
                send_word(frame_raw[i], i == frame_raw.size() - 1, 1'b0, ST_OK);
        end
        drain();
    endtask

    // result receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready = 1'b0;
        end
        else
            res_ch.ready = calm || $urandom_range(0, 99) >= 20;
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected status word: status %0d", res_ch.status);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (res_ch.status !== want.status ||
                    res_ch.message_type !== want.frame_type ||
                    res_ch.message_subtype !== want.frame_subtype ||
                    res_ch.value_one !== want.value_one || res_ch.value_two !== want.value_two ||
                    res_ch.value_three !== want.value_three)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("status word mismatch at %0t", $realtime);
                        $display("  expected: st %0d type %h sub %h v1 %h v2 %h v3 %h",
                                 want.status, want.frame_type, want.frame_subtype,
                                 want.value_one, want.value_two, want.value_three);
                        $display("  actual:   st %0d type %h sub %h v1 %h v2 %h v3 %h",
                                 res_ch.status, res_ch.message_type, res_ch.message_subtype,
                                 res_ch.value_one, res_ch.value_two, res_ch.value_three);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((raw_ch.valid && raw_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stuffed_frame_deframer_test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        raw_ch.valid     = 1'b0;
        raw_ch.raw_byte  = 8'h00;
        raw_ch.last_byte = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_SYNC_FIRST;
        cfg_ch.data      = 8'h00;
        res_ch.ready     = 1'b0;

        cur_sync_first  = SYNC_FIRST_RST;
        cur_sync_second = SYNC_SECOND_RST;
        frame_st        = FRAME_RST;
        held_type       = 8'h00;
        held_subtype    = 8'h00;
        foreach (staged[i])
            staged[i] = 8'h00;
        foreach (held_values[i])
            held_values[i] = 32'h0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].raw, directed_rows[i].last,
                      directed_rows[i].pinned, directed_rows[i].pin_status);
        drain();

        set_pace(1'b1, 1'b0);
        run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST);
        set_pace(1'b0, 1'b1);
        run_phase(8'h00, 8'hFF);
        run_phase(8'hFF, 8'h00);
        // sync bytes that themselves unstuff
        run_phase(ESCAPE_BYTE, ESC_FLAG);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

        if (mismatches == 0 && expected_frames.size() == 0)
            $display("stuffed_frame_deframer_test passed");
        else
            $display("stuffed_frame_deframer_test failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_intf.sv
rtl/core/sfd_unstuff.sv
rtl/core/stuffed_frame_deframer.sv
verif/stuffed_frame_deframer_test.sv
